@@ hdl/paco_pkg.sv @@
// Shared types and constants for the phase accumulator cosine oscillator.
package paco_pkg;

   // Widths of the request and response payloads, the step and their product
   localparam int FREQ_W   = 24;
   localparam int STEP_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = FREQ_W + STEP_W;

   // Bits of phase held by one accumulator cell
   localparam int CELL_W = 8;

   // Peak output amplitude
   localparam int AMPLITUDE = 32767;

   // Register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   typedef enum logic {
      CSR_STEP_PER_HZ = 1'b0,
      CSR_UNMAPPED    = 1'b1
   } csr_index_type;

   localparam logic [STEP_W-1:0] STEP_RESET = 32'd24932237;

   // Control handed from one cell to the next
   typedef struct packed {
      logic valid;
      logic carry;
   } link_type;

endpackage

@@ hdl/paco_cell.sv @@
// One slice of the pipelined phase accumulator, with its carry and skew registers.
module paco_cell
   import paco_pkg::*;
#(
   parameter int ACC_W = 32,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  link_type         prev_link,
   input  logic [ACC_W-1:0] prev_inc,
   input  logic [ACC_W-1:0] prev_phase,
   output link_type         next_link,
   output logic [ACC_W-1:0] next_inc,
   output logic [ACC_W-1:0] next_phase
);

   localparam int LSB = INDEX * CELL_W;

   logic [CELL_W-1:0] acc_ff, acc_in;
   link_type          link_ff, link_in;
   logic [ACC_W-1:0]  inc_ff;
   logic [ACC_W-1:0]  phase_ff, phase_in;
   logic [CELL_W:0]   sum;

   // Add this slice of the increment plus the carry of the slice below
   assign sum = {1'b0, acc_ff} + {1'b0, prev_inc[LSB +: CELL_W]}
                + {{CELL_W{1'b0}}, prev_link.carry};

   always_comb begin
      acc_in        = prev_link.valid ? sum[CELL_W-1:0] : acc_ff;
      link_in.valid = prev_link.valid;
      link_in.carry = prev_link.valid & sum[CELL_W];
      // Insert the phase slice seen before this request's step
      phase_in               = prev_phase;
      phase_in[LSB +: CELL_W] = acc_ff;
   end

   // Hold the phase slice and the link control
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         link_ff <= '0;
      end else if (adv) begin
         acc_ff  <= acc_in;
         link_ff <= link_in;
      end
   end

   // Advance the skewed increment and deskewed phase
   always_ff @(posedge clock) begin
      if (adv) begin
         inc_ff   <= prev_inc;
         phase_ff <= phase_in;
      end
   end

   assign next_link  = link_ff;
   assign next_inc   = inc_ff;
   assign next_phase = phase_ff;

endmodule

@@ hdl/paco_cos_rom.sv @@
// Quarter-wave cosine lookup: phase folding, registered table read and sign restore.
module paco_cos_rom
   import paco_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [TABLE_ADDR_BITS-1:0] addr,
   output logic                       out_valid,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam int FOLD_W = TABLE_ADDR_BITS + 1;
   localparam int IDX_W  = TABLE_ADDR_BITS - 1;
   localparam int QTR_N  = 1 << (TABLE_ADDR_BITS - 2);
   localparam int MAG_W  = SAMPLE_W - 1;

   localparam logic [FOLD_W-1:0] FULL_C = FOLD_W'(1) << TABLE_ADDR_BITS;
   localparam logic [FOLD_W-1:0] HALF_C = FOLD_W'(1) << (TABLE_ADDR_BITS - 1);
   localparam logic [FOLD_W-1:0] QTR_C  = FOLD_W'(1) << (TABLE_ADDR_BITS - 2);

   // Angle of one table step in radians
   localparam real ANG_STEP = 2.0 * 3.14159265358979323846 / real'(4 * QTR_N);

   typedef logic [MAG_W-1:0] lut_type [QTR_N+1];

   // Cosine magnitude over the first quarter cycle, rounded to nearest
   function automatic lut_type build_lut();
      lut_type t;
      real     ang;
      for (int r = 0; r <= QTR_N; r++) begin
         ang  = ANG_STEP * real'(r);
         t[r] = MAG_W'($rtoi(real'(AMPLITUDE) * $cos(ang) + 0.5));
      end
      return t;
   endfunction

   localparam lut_type COS_LUT = build_lut();

   logic [FOLD_W-1:0] r0, r1, r2;
   logic              neg;

   logic             v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             neg1_ff, neg2_ff;
   logic [MAG_W-1:0] mag_ff;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   // Fold the phase into the first quarter; the second and third quarters negate
   always_comb begin
      r0  = {1'b0, addr};
      r1  = (r0 > HALF_C) ? (FULL_C - r0) : r0;
      neg = (r1 > QTR_C);
      r2  = neg ? (HALF_C - r1) : r1;
   end

   assign sample_in = neg2_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

   // Advance the stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Fold register, table read and sign restore
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff    <= r2[IDX_W-1:0];
         neg1_ff   <= neg;
         mag_ff    <= COS_LUT[idx_ff];
         neg2_ff   <= neg1_ff;
         sample_ff <= sample_in;
      end
   end

   assign out_valid = v3_ff;
   assign sample    = sample_ff;

endmodule

@@ hdl/phase_accumulator_cosine_oscillator.sv @@
// Top level of the phase accumulator cosine oscillator with its register port.
//
// Usage: each request on req_ carries one frequency sample (signed Q16.8 Hz).
// For every request one response leaves on rsp_: the cosine of the phase
// before that request's step, scaled by 32767. The phase then advances by
// (frequency * step_per_hz) shifted down to PHASE_BITS and wraps.
// step_per_hz is written over the csr_ port at byte address 0.
// Throughput: one request per cycle while the skid register is free.
// The accumulator is a row of 8-bit cells, each adding its slice to the
// carry registered by the slice below, so the phase loop closes inside one cell.
// Pipeline: a request passes the multiplier register, NUM_CELLS accumulator
// cells, the fold, table read and sign registers and the output register;
// NUM_CELLS is PHASE_BITS / 8 rounded up.
// Reset: the phase clears to zero and step_per_hz returns to 24932237.
// No clearing pass is needed, so requests are taken right after reset.
// Stall: while rsp_tready is low one more result parks in a skid register;
// once that is full the whole pipeline holds and req_tready drops.
module phase_accumulator_cosine_oscillator
   import paco_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 12,
   parameter int PHASE_BITS      = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [23:0] frequency
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [FREQ_W-1:0]     req_tdata,
   // rsp_tdata: [15:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int NUM_CELLS = (PHASE_BITS + CELL_W - 1) / CELL_W;
   localparam int ACC_W     = NUM_CELLS * CELL_W;
   localparam int SHIFT     = 48 - PHASE_BITS;

   logic adv;

   logic [STEP_W-1:0]        step_ff;
   csr_index_type            csr_index;
   logic                     csr_write;

   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] mul_ff;
   logic signed [PROD_W-1:0] inc_shift;
   logic                     mul_valid_ff;

   link_type                 link_chain  [NUM_CELLS+1];
   logic [ACC_W-1:0]         inc_chain   [NUM_CELLS+1];
   logic [ACC_W-1:0]         phase_chain [NUM_CELLS+1];

   logic                       pipe_valid;
   logic signed [SAMPLE_W-1:0] pipe_sample;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [SAMPLE_W-1:0] skid_sample_ff;
   logic                skid_load;

   // Register port: one register, always ready
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == CSR_STEP_PER_HZ) ? step_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_write && (csr_index == CSR_STEP_PER_HZ)) begin
         step_ff <= csr_pwdata;
      end
   end

   // The pipeline moves whenever the skid register is free
   assign adv        = ~skid_valid_ff;
   assign req_tready = adv;

   // Multiply the request frequency by the step per hertz
   assign prod_full = $signed(req_tdata) * $signed({1'b0, step_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_ff <= prod_full[PROD_W-1:0];
      end
   end

   // Scale the product to a phase increment (floor shift, wraps modulo the phase)
   assign inc_shift = mul_ff >>> SHIFT;

   assign link_chain[0]  = '{valid: mul_valid_ff, carry: 1'b0};
   assign inc_chain[0]   = inc_shift[ACC_W-1:0];
   assign phase_chain[0] = '0;

   // Row of accumulator cells, lowest slice first
   for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
      paco_cell #(
         .ACC_W (ACC_W),
         .INDEX (j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .prev_link  (link_chain[j]),
         .prev_inc   (inc_chain[j]),
         .prev_phase (phase_chain[j]),
         .next_link  (link_chain[j+1]),
         .next_inc   (inc_chain[j+1]),
         .next_phase (phase_chain[j+1])
      );
   end

   // Look up the cosine of the top phase bits
   paco_cos_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_cos_rom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (link_chain[NUM_CELLS].valid),
      .addr      (phase_chain[NUM_CELLS][PHASE_BITS-1 -: TABLE_ADDR_BITS]),
      .out_valid (pipe_valid),
      .sample    (pipe_sample)
   );

   // Output register with a one-entry skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      skid_valid_in = skid_valid_ff;
      skid_load     = 1'b0;
      priority if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_sample_in = skid_sample_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_valid) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = pipe_sample;
         end else begin
            skid_valid_in = 1'b1;
            skid_load     = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      if (skid_load) begin
         skid_sample_ff <= pipe_sample;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;

`ifndef SYNTHESIS
   // A parked result always sits behind a pending response
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while the response register is empty");

   // The skid fills only when a stalled response meets a finished result
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (!skid_valid_ff && !(pipe_valid && rsp_valid_ff && !rsp_tready))
      |=> !skid_valid_ff)
      else $error("skid filled without a stalled response");

   // Cosine magnitude never exceeds the amplitude
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sample_ff != 16'h8000))
      else $error("sample outside the cosine range");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the phase accumulator cosine oscillator.
`timescale 1ns / 100ps

module tb;
   import paco_pkg::*;

   localparam int TABLE_ADDR_BITS = 12;
   localparam int PHASE_BITS      = 32;
   localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;
   // Frequency is Q8 and step_per_hz carries 2^40, so a full phase turn is 2^48 in the product
   localparam int INC_SHIFT       = 48 - PHASE_BITS;
   localparam int LATENCY         = (PHASE_BITS + 7) / 8 + 4;

   localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] ONE_Q60    = 64'd1 << 60;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [FREQ_W-1:0]     req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Oscillator state as the testbench sees it
   logic [PHASE_BITS-1:0] osc_phase = '0;
   logic [STEP_W-1:0]     osc_step  = STEP_RESET;

   logic [SAMPLE_W-1:0]   expected_samples [$];
   int                    error_count     = 0;
   int                    rsp_hold_cycles = 0;
   bit                    no_idle         = 1'b0;

   phase_accumulator_cosine_oscillator #(
      .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
      .PHASE_BITS     (PHASE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor of (a * b) / 2^60 for Q60 operands
   function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[123:60];
   endfunction

   // Alternating Taylor series of sine (odd) or cosine around zero, in Q60
   function automatic logic [63:0] cosine_series(input logic [63:0] x, input bit odd);
      logic [63:0] x2, term, total, k;
      bit          subtract;
      int          i;
      x2       = q60_product(x, x);
      term     = odd ? x : ONE_Q60;
      total    = term;
      k        = odd ? 64'd2 : 64'd1;
      subtract = 1'b1;
      for (i = 0; i < 24 && term != 0; i++) begin
         term = q60_product(term, x2) / (k * (k + 64'd1));
         k    = k + 64'd2;
         if (subtract) total = total - term;
         else total = total + term;
         subtract = !subtract;
      end
      return total;
   endfunction

   // Rounded amplitude-scaled cosine of one table index, folded to the first octant
   function automatic logic [SAMPLE_W-1:0] cosine_of_index(
      input logic [TABLE_ADDR_BITS-1:0] p
   );
      logic [TABLE_ADDR_BITS:0] r;
      bit                       neg, use_sin;
      logic [63:0]              x, c, scaled;
      r       = {1'b0, p};
      neg     = 1'b0;
      use_sin = 1'b0;
      if (r > TABLE_SIZE / 2) r = (TABLE_ADDR_BITS + 1)'(TABLE_SIZE - r);
      if (r > TABLE_SIZE / 4) begin
         r   = (TABLE_ADDR_BITS + 1)'(TABLE_SIZE / 2 - r);
         neg = 1'b1;
      end
      if (r > TABLE_SIZE / 8) begin
         r       = (TABLE_ADDR_BITS + 1)'(TABLE_SIZE / 4 - r);
         use_sin = 1'b1;
      end
      x = q60_product(TWO_PI_Q60, 64'(r) << (60 - TABLE_ADDR_BITS));
      c = cosine_series(x, use_sin);
      if (c > ONE_Q60) c = ONE_Q60;
      scaled = ((c >> 20) * 64'(AMPLITUDE) + (64'd1 << 39)) >> 40;
      return neg ? SAMPLE_W'(-scaled) : SAMPLE_W'(scaled);
   endfunction

   // Sample of the current phase, then step the phase by the scaled frequency
   function automatic logic [SAMPLE_W-1:0] advance_oscillator(input logic [FREQ_W-1:0] f);
      longint              freq64, step64, product;
      logic [SAMPLE_W-1:0] sample;
      sample    = cosine_of_index(osc_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS]);
      freq64    = longint'(signed'(f));
      step64    = longint'({32'd0, osc_step});
      product   = (freq64 * step64) >>> INC_SHIFT;
      osc_phase = osc_phase + product[PHASE_BITS-1:0];
      return sample;
   endfunction

   function automatic logic [FREQ_W-1:0] random_frequency();
      case ($urandom_range(0, 3))
         0, 1: return FREQ_W'($urandom());
         2: return FREQ_W'($urandom_range(0, 8191) - 4096);
         default: return FREQ_W'(32'h80_0000 + $urandom_range(0, 15) - 8);
      endcase
   endfunction

   task automatic report_error(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      error_count++;
      if (error_count <= 10) $display("%s: expected %h, got %h", what, want, got);
   endtask

   // Offer one frequency sample after a random gap and predict its response
   task automatic send_frequency(input logic [FREQ_W-1:0] f);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
      expected_samples.push_back(advance_oscillator(f));
   endtask

   // Stop offering and hold until every predicted response has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_STEP_PER_HZ) osc_step = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_step();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {CSR_STEP_PER_HZ, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== osc_step) report_error("step_per_hz readback", osc_step, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reset value, then a write to the unmapped slot that must change nothing
   task automatic test_register_access();
      csr_check_step();
      csr_write(CSR_UNMAPPED, $urandom());
      csr_check_step();
   endtask

   task automatic test_directed();
      logic [FREQ_W-1:0] corner [7];
      corner = '{24'h00_0000, 24'h00_0001, 24'hFF_FFFF, 24'h7F_FFFF,
                 24'h80_0000, 24'h55_5555, 24'hAA_AAAA};
      // Step 2^25 with frequency 2^20 moves the table index one octant per request;
      // start from the reset phase so every fold boundary is hit, then wrap and reverse
      csr_write(CSR_STEP_PER_HZ, 32'h0200_0000);
      repeat (9) send_frequency(24'h10_0000);
      repeat (3) send_frequency(24'hF0_0000);
      // Field extremes at the reset step
      drain();
      csr_write(CSR_STEP_PER_HZ, STEP_RESET);
      foreach (corner[i]) send_frequency(corner[i]);
      // Zero step holds the phase
      drain();
      csr_write(CSR_STEP_PER_HZ, 32'd0);
      send_frequency(24'h7F_FFFF);
      send_frequency(24'h80_0000);
      // Largest step with both frequency extremes
      drain();
      csr_write(CSR_STEP_PER_HZ, 32'hFFFF_FFFF);
      send_frequency(24'h7F_FFFF);
      send_frequency(24'h80_0000);
   endtask

   task automatic test_random_settings();
      logic [STEP_W-1:0] steps [5];
      steps    = '{STEP_RESET, 32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd0};
      steps[4] = $urandom();
      foreach (steps[s]) begin
         drain();
         csr_write(CSR_STEP_PER_HZ, steps[s]);
         csr_check_step();
         repeat (130) send_frequency(random_frequency());
      end
   endtask

   // Receiver holds off long enough that the block fills and stalls its input
   task automatic test_backpressure();
      drain();
      csr_write(CSR_STEP_PER_HZ, $urandom());
      no_idle         = 1'b1;
      rsp_hold_cycles = 80;
      repeat (60) send_frequency(random_frequency());
      no_idle = 1'b0;
      drain();
   endtask

   // Full rate on both sides
   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (150) send_frequency(random_frequency());
      no_idle = 1'b0;
   endtask

   // Accept responses, compare with the oldest prediction, then pick the next stall
   initial begin : response_sink
      int                  stall;
      logic [SAMPLE_W-1:0] want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_error("unpredicted response", '0, 32'(rsp_tdata));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want) report_error("sample", 32'(want), 32'(rsp_tdata));
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : run
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_directed();
      test_random_settings();
      test_backpressure();
      test_back_to_back();
      drain();
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
